### sv/rac_pkg.sv
// ----------------------------------------------------------------------------
// rac_pkg: shared types and constants for the risk-adjusted cusum
// Holds the queue item, the result record, the log unit handshake and the
// fixed constants of the weight calculation.
// ----------------------------------------------------------------------------
package rac_pkg;

  // ln 2 in Q.30
  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  // register reset values
  localparam logic [15:0] ODDS_RESET   = 16'd512;
  localparam logic [30:0] THRESH_RESET = 31'd294912;

  // register indexes (paddr bit 2)
  localparam logic REG_ODDS_RATIO      = 1'b0;
  localparam logic REG_ALARM_THRESHOLD = 1'b1;

  // input clamp and argument scale
  localparam logic [16:0] RISK_ONE = 17'd65536;
  localparam logic [31:0] ARG_ONE  = 32'd16777216;

  // saturation bounds of the sums
  localparam logic [30:0] UPPER_MAX = 31'h7fff_ffff;
  localparam logic signed [31:0] LOWER_MIN = 32'sh8000_0000;

  // classified item between front and back
  typedef struct packed {
    logic [31:0] y_arg;   // 2^24 + risk * (odds - 256)
    logic [15:0] odds;    // odds ratio with zero mapped to one
    logic        outcome;
  } rac_item_t;

  // one result record
  typedef struct packed {
    logic [31:0]        item_index;
    logic [30:0]        upper_start;
    logic [30:0]        upper_finish;
    logic signed [31:0] lower_start;
    logic signed [31:0] lower_finish;
  } rac_result_t;

  // log unit request and response
  typedef struct packed {
    logic        start;
    logic [31:0] arg;
  } rac_ln_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] value;
  } rac_ln_rsp_t;

endpackage

### sv/rac_fifo.sv
// ----------------------------------------------------------------------------
// rac_fifo: short item queue between front and back
// Register-based queue of classified items with full and empty flags.
// ----------------------------------------------------------------------------
module rac_fifo
  import rac_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_en,
  input  rac_item_t wr_data,
  input  logic      rd_en,
  output rac_item_t rd_data,
  output logic      full,
  output logic      empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  rac_item_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### sv/rac_front.sv
// ----------------------------------------------------------------------------
// rac_front: input classification
// Clamps the risk, fixes a zero odds ratio and forms the log argument
// 2^24 + risk * (odds - 256) for the queue.
// ----------------------------------------------------------------------------
module rac_front
  import rac_pkg::*;
(
  input  logic [16:0] risk,
  input  logic        outcome,
  input  logic [15:0] odds_ratio,
  output rac_item_t   item
);

  logic [16:0]        risk_c;
  logic [15:0]        odds_eff;
  logic signed [16:0] odds_diff;
  logic signed [34:0] prod;
  logic signed [34:0] y_full;

  always_comb begin
    risk_c    = (risk > RISK_ONE) ? RISK_ONE : risk;
    odds_eff  = (odds_ratio == '0) ? 16'd1 : odds_ratio;
    odds_diff = $signed({1'b0, odds_eff}) - 17'sd256;
    prod      = $signed({1'b0, risk_c}) * odds_diff;
    // always positive and below 2^32
    y_full    = $signed({3'b000, ARG_ONE}) + prod;
    item.y_arg   = y_full[31:0];
    item.odds    = odds_eff;
    item.outcome = outcome;
  end

endmodule

### sv/rac_ln.sv
// ----------------------------------------------------------------------------
// rac_ln: iterative natural log unit
// ln(arg * 2^-24) with FRAC_BITS fraction bits: binary-search normalize,
// thirty squaring steps for the log2 bits, scale by ln 2, round.
// ----------------------------------------------------------------------------
module rac_ln
  import rac_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  rac_ln_req_t req,
  output rac_ln_rsp_t rsp
);

  localparam int SH = 60 - FRAC_BITS;
  localparam logic [63:0] HALF = 64'd1 << (SH - 1);
  localparam logic [4:0] NORM_LAST = 5'd4;
  localparam logic [4:0] SQ_LAST   = 5'd29;

  typedef enum logic [2:0] {
    S_IDLE, S_NORM, S_SQ, S_MUL, S_SUM, S_ABS, S_RND
  } state_t;

  state_t             state;
  logic [4:0]         cnt;
  logic [31:0]        x;
  logic [4:0]         e;
  logic [30:0]        m;
  logic [29:0]        bits;
  logic [59:0]        p_lo;
  logic signed [37:0] p_hi;
  logic signed [63:0] prod;
  logic [63:0]        mag;
  logic               neg;

  logic [31:0] x_next;
  logic [4:0]  e_next;
  logic [61:0] sq;
  logic [31:0] sq_t;
  logic signed [6:0] e_off;
  logic [63:0] rnd_full;
  logic [63:0] rnd;

  // one binary-search step of the leading-one normalize
  always_comb begin
    x_next = x;
    e_next = e;
    case (cnt[2:0])
      3'd0: if (x[31:16] == '0) begin x_next = x << 16; e_next = e - 5'd16; end
      3'd1: if (x[31:24] == '0) begin x_next = x << 8;  e_next = e - 5'd8;  end
      3'd2: if (x[31:28] == '0) begin x_next = x << 4;  e_next = e - 5'd4;  end
      3'd3: if (x[31:30] == '0) begin x_next = x << 2;  e_next = e - 5'd2;  end
      default: if (!x[31]) begin x_next = x << 1; e_next = e - 5'd1; end
    endcase
  end

  always_comb begin
    sq       = m * m;
    sq_t     = sq[61:30];
    e_off    = $signed({2'b00, e}) - 7'sd24;
    rnd_full = mag + HALF;
    rnd      = rnd_full >> SH;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= (state == S_RND);
      unique case (state)
        S_IDLE: begin
          if (req.start) begin
            x     <= (req.arg == '0) ? 32'd1 : req.arg;
            e     <= 5'd31;
            cnt   <= '0;
            state <= S_NORM;
          end
        end
        S_NORM: begin
          x <= x_next;
          e <= e_next;
          if (cnt == NORM_LAST) begin
            m     <= x_next[31:1];
            bits  <= '0;
            cnt   <= '0;
            state <= S_SQ;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_SQ: begin
          if (sq_t[31]) begin
            m    <= sq_t[31:1];
            bits <= {bits[28:0], 1'b1};
          end else begin
            m    <= sq_t[30:0];
            bits <= {bits[28:0], 1'b0};
          end
          if (cnt == SQ_LAST) begin
            state <= S_MUL;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_MUL: begin
          p_lo  <= bits * LN2_Q30;
          p_hi  <= e_off * $signed({1'b0, LN2_Q30});
          state <= S_SUM;
        end
        S_SUM: begin
          prod  <= ($signed(64'(p_hi)) <<< 30) + $signed({4'b0000, p_lo});
          state <= S_ABS;
        end
        S_ABS: begin
          neg   <= prod[63];
          mag   <= prod[63] ? 64'(-prod) : 64'(prod);
          state <= S_RND;
        end
        S_RND: begin
          rsp.value <= neg ? -$signed(rnd[31:0]) : $signed(rnd[31:0]);
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/rac_back.sv
// ----------------------------------------------------------------------------
// rac_back: weight and cusum update
// Pops a classified item, runs the log unit for the weight, updates both
// sums and the item counter and holds the result until it is taken.
// ----------------------------------------------------------------------------
module rac_back
  import rac_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [30:0] alarm_threshold,
  input  logic        q_empty,
  input  rac_item_t   q_data,
  output logic        q_pop,
  input  logic        res_pop,
  output logic        res_valid,
  output rac_result_t res
);

  typedef enum logic [1:0] {
    S_IDLE, S_LN_Y, S_LN_R, S_UPDATE
  } state_t;

  state_t             state;
  rac_ln_req_t        ln_req;
  rac_ln_rsp_t        ln_rsp;
  rac_item_t          item;
  logic [30:0]        upper_sum;
  logic signed [31:0] lower_sum;
  logic [31:0]        item_counter;
  logic [30:0]        us;
  logic signed [31:0] ls;
  logic signed [32:0] w;

  logic               lower_hit;
  logic signed [34:0] uf_full;
  logic signed [34:0] lf_full;
  logic [30:0]        uf;
  logic signed [31:0] lf;
  logic [31:0]        item_counter_next;
  logic               ln_start_next;

  rac_ln #(
    .FRAC_BITS(FRAC_BITS)
  ) u_ln (
    .clk(clk),
    .rst(rst),
    .req(ln_req),
    .rsp(ln_rsp)
  );

  assign q_pop = (state == S_IDLE) && !q_empty;

  always_comb begin
    lower_hit = $signed({lower_sum[31], lower_sum}) <= -$signed({2'b00, alarm_threshold});
    uf_full   = $signed({4'b0000, us}) + 35'(w);
    lf_full   = 35'(ls) + 35'(w);
    if (uf_full < 0) begin
      uf = '0;
    end else if (uf_full > $signed({4'b0000, UPPER_MAX})) begin
      uf = UPPER_MAX;
    end else begin
      uf = uf_full[30:0];
    end
    if (lf_full > 0) begin
      lf = '0;
    end else if (lf_full < 35'(LOWER_MIN)) begin
      lf = LOWER_MIN;
    end else begin
      lf = lf_full[31:0];
    end
    item_counter_next = (item_counter == '1) ? item_counter : item_counter + 1'b1;
    // log of the argument on pop; log of the odds after it only when outcome is set
    ln_start_next = ((state == S_IDLE) && !q_empty) ||
                    ((state == S_LN_Y) && ln_rsp.done && item.outcome);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      ln_req.start <= 1'b0;
      res_valid    <= 1'b0;
      upper_sum    <= '0;
      lower_sum    <= '0;
      item_counter <= '0;
    end else begin
      ln_req.start <= ln_start_next;
      if (res_pop && res_valid) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            item         <= q_data;
            // restart rule on the carried-in sums
            us           <= (upper_sum >= alarm_threshold) ? '0 : upper_sum;
            ls           <= lower_hit ? '0 : lower_sum;
            ln_req.arg   <= q_data.y_arg;
            state        <= S_LN_Y;
          end
        end
        S_LN_Y: begin
          if (ln_rsp.done) begin
            w <= -(33'(ln_rsp.value));
            if (item.outcome) begin
              ln_req.arg   <= {item.odds, 16'h0000};
              state        <= S_LN_R;
            end else begin
              state <= S_UPDATE;
            end
          end
        end
        S_LN_R: begin
          if (ln_rsp.done) begin
            w     <= w + 33'(ln_rsp.value);
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (!res_valid) begin
            upper_sum        <= uf;
            lower_sum        <= lf;
            item_counter     <= item_counter_next;
            res.item_index   <= item_counter_next;
            res.upper_start  <= us;
            res.upper_finish <= uf;
            res.lower_start  <= ls;
            res.lower_finish <= lf;
            res_valid        <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/risk_adjusted_cusum.sv
// ----------------------------------------------------------------------------
// risk_adjusted_cusum: two-sided risk-adjusted cusum
// Per request forms the log-likelihood weight from risk and outcome and
// updates an upper and a lower cusum with restart at the control limit.
//
//   channel   direction  handshake                fields
//   input     in         push / full              risk, outcome
//   result    out        pop / empty              item_index, upper_start,
//                                                 upper_finish, lower_start,
//                                                 lower_finish
//   config    in/out     psel, penable, pwrite    paddr, pwdata, prdata
//
// a request runs the log unit once between the queue and its result,
// twice when outcome is set; each log steps the iterative log unit
// through its normalize, squaring, multiply, sum, absolute and round states
// the front takes requests into a two-entry queue while the back works
// reset is synchronous; sums, counter and queue clear, registers take
// their defaults; a result waiting on pop stalls the back only
// ----------------------------------------------------------------------------
module risk_adjusted_cusum
  import rac_pkg::*;
#(
  parameter int FRAC_BITS   = 16,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input requests
  input  logic               push,
  output logic               full,
  input  logic [16:0]        risk,
  input  logic               outcome,
  // results
  input  logic               pop,
  output logic               empty,
  output logic [31:0]        item_index,
  output logic [30:0]        upper_start,
  output logic [30:0]        upper_finish,
  output logic signed [31:0] lower_start,
  output logic signed [31:0] lower_finish
);

  // configuration registers
  logic [15:0] odds_ratio;
  logic [30:0] alarm_threshold;
  logic        cfg_wr;

  // front to queue to back
  rac_item_t   front_item;
  rac_item_t   q_data;
  logic        q_empty;
  logic        q_pop;

  // result register in the back
  logic        res_valid;
  rac_result_t res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // register index is paddr bit 2, byte lanes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      odds_ratio      <= ODDS_RESET;
      alarm_threshold <= THRESH_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_ODDS_RATIO:      odds_ratio      <= pwdata[15:0];
        REG_ALARM_THRESHOLD: alarm_threshold <= pwdata[30:0];
        default:             odds_ratio      <= odds_ratio;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ODDS_RATIO:      prdata = {16'h0000, odds_ratio};
      REG_ALARM_THRESHOLD: prdata = {1'b0, alarm_threshold};
      default:             prdata = '0;
    endcase
  end

  // classify the request: clamp risk, form the log argument
  rac_front u_front (
    .risk      (risk),
    .outcome   (outcome),
    .odds_ratio(odds_ratio),
    .item      (front_item)
  );

  // short queue decouples request intake from the log unit
  rac_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (push),
    .wr_data(front_item),
    .rd_en  (q_pop),
    .rd_data(q_data),
    .full   (full),
    .empty  (q_empty)
  );

  // weight, restart rule, saturating sums and result register
  rac_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .alarm_threshold(alarm_threshold),
    .q_empty        (q_empty),
    .q_data         (q_data),
    .q_pop          (q_pop),
    .res_pop        (pop),
    .res_valid      (res_valid),
    .res            (res)
  );

  // result ports show the single waiting result held in the back
  assign empty        = !res_valid;
  assign item_index   = res.item_index;
  assign upper_start  = res.upper_start;
  assign upper_finish = res.upper_finish;
  assign lower_start  = res.lower_start;
  assign lower_finish = res.lower_finish;

endmodule

### verif/risk_adjusted_cusum_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// risk_adjusted_cusum_tb: self-checking bench for the two-sided cusum
// Drives risk/outcome requests through the push/full side and pops results
// under several idle and stall mixes. Each request is run through a local
// fixed-point model of the log weight and both sums; results are checked
// field by field in order. Registers are changed over the apb port between
// phases, and two short climbs push the sums far from zero at the widest limit.
// ----------------------------------------------------------------------------
module risk_adjusted_cusum_tb
  import rac_pkg::*;
();

  localparam int FRAC_BITS     = 16;
  localparam int LOG_SHIFT     = 60 - FRAC_BITS;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 160;
  // steady ln(256) steps per request in one direction
  localparam int CLIMB_ITEMS   = 120;
  localparam int SETTLE_CYCLES = 200;
  localparam int REPORT_LIMIT  = 10;
  localparam int DIRECTED_ROWS = 28;

  // idle mixes
  localparam int IDLE_NONE   = 0;
  localparam int IDLE_SEND   = 1;
  localparam int IDLE_POP    = 2;
  localparam int IDLE_BOTH   = 3;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               push;
  logic               full;
  logic [16:0]        risk;
  logic               outcome;
  logic               pop = 1'b0;
  logic               empty;
  logic [31:0]        item_index;
  logic [30:0]        upper_start;
  logic [30:0]        upper_finish;
  logic signed [31:0] lower_start;
  logic signed [31:0] lower_finish;

  risk_adjusted_cusum dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .push         (push),
    .full         (full),
    .risk         (risk),
    .outcome      (outcome),
    .pop          (pop),
    .empty        (empty),
    .item_index   (item_index),
    .upper_start  (upper_start),
    .upper_finish (upper_finish),
    .lower_start  (lower_start),
    .lower_finish (lower_finish)
  );

  // one directed request, with the result typed in where it is obvious
  typedef struct {
    logic [16:0] risk;
    logic        adverse;
    logic        pinned;
    rac_result_t want;
  } stim_row_t;

  // model copy of registers and sums
  logic [15:0]  odds_q;
  logic [30:0]  limit_q;
  longint       upper_sum;
  longint       lower_sum;
  logic [31:0]  request_count;

  // results still owed by the block, oldest first
  rac_result_t  pending_results[$];

  // handoff of a typed expectation from the driver to the monitor
  logic         pinned_valid;
  rac_result_t  pinned_want;

  int unsigned  send_idle_pct;
  int unsigned  pop_stall_pct;
  int unsigned  mismatches;
  int unsigned  requests_taken;
  int unsigned  results_checked;
  int unsigned  upper_restarts;
  int unsigned  lower_restarts;
  int unsigned  upper_clips;
  int unsigned  lower_clips;

  // ln(v * 2^-24) with FRAC_BITS fraction bits, fixed 30-step log2
  function automatic longint scaled_ln(input longint arg);
    logic [63:0] v;
    logic [63:0] m;
    logic [63:0] bits;
    logic [63:0] mag;
    longint      l2;
    longint      prod;
    int          msb;
    v = (arg == 0) ? 64'd1 : 64'(arg);
    msb = 0;
    for (int i = 0; i < 32; i++)
      if (v[i]) msb = i;
    m = (msb <= 30) ? (v << (30 - msb)) : (v >> (msb - 30));
    bits = '0;
    for (int k = 0; k < 30; k++) begin
      m = (m * m) >> 30;
      bits = bits << 1;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        bits[0] = 1'b1;
      end
    end
    l2 = (longint'(msb) - 64'sd24) * 64'sd1073741824 + longint'(bits);
    prod = l2 * longint'(LN2_Q30);
    mag = (prod < 0) ? 64'(-prod) : 64'(prod);
    mag = (mag + (64'd1 << (LOG_SHIFT - 1))) >> LOG_SHIFT;
    return (prod < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  // weight, restart rule, clamp and saturation for one request
  function automatic rac_result_t cusum_update(input logic [16:0] r, input logic adverse);
    rac_result_t res;
    longint      odds;
    longint      rc;
    longint      arg;
    longint      w;
    longint      us;
    longint      uf;
    longint      ls;
    longint      lf;
    odds = (odds_q == '0) ? 64'sd1 : longint'(odds_q);
    rc = (r > RISK_ONE) ? longint'(RISK_ONE) : longint'(r);
    arg = longint'(ARG_ONE) + rc * (odds - 64'sd256);
    w = -scaled_ln(arg);
    if (adverse) w += scaled_ln(odds << 16);

    // restart once the limit was reached on the previous request
    if (upper_sum >= longint'(limit_q)) begin
      if (upper_sum != 0) upper_restarts++;
      us = 0;
    end else begin
      us = upper_sum;
    end
    uf = us + w;
    if (uf < 0) uf = 0;
    if (uf > longint'(UPPER_MAX)) begin
      uf = longint'(UPPER_MAX);
      upper_clips++;
    end

    if (lower_sum <= -longint'(limit_q)) begin
      if (lower_sum != 0) lower_restarts++;
      ls = 0;
    end else begin
      ls = lower_sum;
    end
    lf = ls + w;
    if (lf > 0) lf = 0;
    if (lf < longint'(LOWER_MIN)) begin
      lf = longint'(LOWER_MIN);
      lower_clips++;
    end

    upper_sum = uf;
    lower_sum = lf;
    if (request_count != 32'hffff_ffff) request_count++;

    res.item_index   = request_count;
    res.upper_start  = us[30:0];
    res.upper_finish = uf[30:0];
    res.lower_start  = ls[31:0];
    res.lower_finish = lf[31:0];
    return res;
  endfunction

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t: %s mismatch on result %0d: expected %0d, got %0d",
                 $realtime, name, results_checked, want, got);
    end
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side: pop stalls at the current rate, changed on the falling edge
  always @(negedge clk) begin
    pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  // monitor: model each accepted request, check each accepted result
  always @(posedge clk) begin
    rac_result_t model;
    rac_result_t want;
    if (!rst) begin
      if (push && !full) begin
        model = cusum_update(risk, outcome);
        pending_results.push_back(pinned_valid ? pinned_want : model);
        requests_taken++;
      end
      if (pop && !empty) begin
        results_checked++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: result with no request waiting, index %0d",
                     $realtime, item_index);
        end else begin
          want = pending_results.pop_front();
          compare_field("item_index", longint'(want.item_index), longint'(item_index));
          compare_field("upper_start", longint'(want.upper_start), longint'(upper_start));
          compare_field("upper_finish", longint'(want.upper_finish),
                        longint'(upper_finish));
          compare_field("lower_start", longint'(want.lower_start), longint'(lower_start));
          compare_field("lower_finish", longint'(want.lower_finish),
                        longint'(lower_finish));
        end
      end
    end
  end

  // one apb transfer: setup, access, then idle bus
  task automatic reg_access(input logic wr, input logic idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // write a register, read it back, and update the model copy
  task automatic set_register(input logic idx, input logic [31:0] value);
    logic [31:0] dummy;
    logic [31:0] back;
    logic [31:0] want;
    reg_access(1'b1, idx, value, dummy);
    if (idx == REG_ODDS_RATIO) begin
      odds_q = value[15:0];
      want = {16'd0, value[15:0]};
    end else begin
      limit_q = value[30:0];
      want = {1'b0, value[30:0]};
    end
    reg_access(1'b0, idx, '0, back);
    compare_field("register readback", longint'(want), longint'(back));
  endtask

  // present one request after a random gap, hold it until taken
  task automatic send_request(input logic [16:0] r, input logic adverse);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push    <= 1'b1;
    risk    <= r;
    outcome <= adverse;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  // stop sending and wait until every owed result has come back
  task automatic drain_results();
    push <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic set_idling(input int mix);
    send_idle_pct = (mix == IDLE_SEND) ? 82 : (mix == IDLE_BOTH) ? 33 : 0;
    pop_stall_pct = (mix == IDLE_POP) ? 82 : (mix == IDLE_BOTH) ? 33 : 0;
  endtask

  // directed rows; the first five run at the reset settings (odds 2.0, limit 4.5)
  // where ln 2 comes out as 45426
  stim_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
    // nothing at stake: zero weight
    '{17'd0,      1'b0, 1'b1, '{32'd1, 31'd0,     31'd0,     32'sd0,      32'sd0}},
    // adverse at zero risk: +ln 2
    '{17'd0,      1'b1, 1'b1, '{32'd2, 31'd0,     31'd45426, 32'sd0,      32'sd0}},
    // certain risk, good outcome: -ln 2
    '{17'd65536,  1'b0, 1'b1, '{32'd3, 31'd45426, 31'd0,     32'sd0,      -32'sd45426}},
    // risk above one clamps to one
    '{17'd131071, 1'b0, 1'b1, '{32'd4, 31'd0,     31'd0,     -32'sd45426, -32'sd90852}},
    // certain risk, adverse outcome: weights cancel
    '{17'd65536,  1'b1, 1'b1, '{32'd5, 31'd0,     31'd0,     -32'sd90852, -32'sd90852}},
    '{17'd65537,  1'b1, 1'b0, '{32'd0, 31'd0, 31'd0, 32'sd0, 32'sd0}},
    '{17'd32768,  1'b1, 1'b0, '{32'd0, 31'd0, 31'd0, 32'sd0, 32'sd0}},
    '{17'd1,      1'b0, 1'b0, '{32'd0, 31'd0, 31'd0, 32'sd0, 32'sd0}},
    '{17'h05555,  1'b0, 1'b0, '{32'd0, 31'd0, 31'd0, 32'sd0, 32'sd0}},
    '{17'h0aaaa,  1'b1, 1'b0, '{32'd0, 31'd0, 31'd0, 32'sd0, 32'sd0}},
    '{17'h0ffff,  1'b0, 1'b0, '{32'd0, 31'd0, 31'd0, 32'sd0, 32'sd0}},
    '{17'h15555,  1'b0, 1'b0, '{32'd0, 31'd0, 31'd0, 32'sd0, 32'sd0}},
    // upper sum climbs past the limit and restarts
    '{17'd0,      1'b1, 1'b0, '{32'd0, 31'd0, 31'd0, 32'sd0, 32'sd0}},
    '{17'd0,      1'b1, 1'b0, '{32'd0, 31'd0, 31'd0, 32'sd0, 32'sd0}},
    '{17'd0,      1'b1, 1'b0, '{32'd0, 31'd0, 31'd0, 32'sd0, 32'sd0}},
    '{17'd0,      1'b1, 1'b0, '{32'd0, 31'd0, 31'd0, 32'sd0, 32'sd0}},
    '{17'd0,      1'b1, 1'b0, '{32'd0, 31'd0, 31'd0, 32'sd0, 32'sd0}},
    '{17'd0,      1'b1, 1'b0, '{32'd0, 31'd0, 31'd0, 32'sd0, 32'sd0}},
    '{17'd0,      1'b1, 1'b0, '{32'd0, 31'd0, 31'd0, 32'sd0, 32'sd0}},
    '{17'd0,      1'b1, 1'b0, '{32'd0, 31'd0, 31'd0, 32'sd0, 32'sd0}},
    // lower sum falls past the limit and restarts
    '{17'd65536,  1'b0, 1'b0, '{32'd0, 31'd0, 31'd0, 32'sd0, 32'sd0}},
    '{17'd65536,  1'b0, 1'b0, '{32'd0, 31'd0, 31'd0, 32'sd0, 32'sd0}},
    '{17'd65536,  1'b0, 1'b0, '{32'd0, 31'd0, 31'd0, 32'sd0, 32'sd0}},
    '{17'd65536,  1'b0, 1'b0, '{32'd0, 31'd0, 31'd0, 32'sd0, 32'sd0}},
    '{17'd65536,  1'b0, 1'b0, '{32'd0, 31'd0, 31'd0, 32'sd0, 32'sd0}},
    '{17'd65536,  1'b0, 1'b0, '{32'd0, 31'd0, 31'd0, 32'sd0, 32'sd0}},
    '{17'd65536,  1'b0, 1'b0, '{32'd0, 31'd0, 31'd0, 32'sd0, 32'sd0}},
    '{17'd0,      1'b0, 1'b0, '{32'd0, 31'd0, 31'd0, 32'sd0, 32'sd0}}
  };

  // stimulus
  initial begin
    logic [31:0] back;
    logic [15:0] odds;
    logic [30:0] limit;
    logic [16:0] r;
    int unsigned adverse_pct;

    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    push         = 1'b0;
    risk         = '0;
    outcome      = 1'b0;
    pinned_valid = 1'b0;
    pinned_want  = '0;
    odds_q       = ODDS_RESET;
    limit_q      = THRESH_RESET;
    upper_sum    = 0;
    lower_sum    = 0;
    request_count   = '0;
    mismatches      = 0;
    requests_taken  = 0;
    results_checked = 0;
    upper_restarts  = 0;
    lower_restarts  = 0;
    upper_clips     = 0;
    lower_clips     = 0;
    set_idling(IDLE_NONE);

    // reset held from the start, released on a falling edge
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // registers come up at their defaults
    reg_access(1'b0, REG_ODDS_RATIO, '0, back);
    compare_field("odds_ratio after reset", longint'(ODDS_RESET), longint'(back));
    reg_access(1'b0, REG_ALARM_THRESHOLD, '0, back);
    compare_field("alarm_threshold after reset", longint'(THRESH_RESET), longint'(back));

    // directed table at reset settings
    foreach (directed_rows[i]) begin
      pinned_valid = directed_rows[i].pinned;
      pinned_want  = directed_rows[i].want;
      send_request(directed_rows[i].risk, directed_rows[i].adverse);
    end
    pinned_valid = 1'b0;
    drain_results();

    // random phases: settings swept through extremes, idle mix rotates
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin odds = ODDS_RESET; limit = THRESH_RESET; end
        // odds zero behaves as 1/256, zero limit restarts every request
        1: begin odds = 16'd0; limit = 31'd0; end
        2: begin odds = 16'hffff; limit = UPPER_MAX; end
        3: begin odds = 16'd1; limit = 31'd65536; end
        // odds of one: every weight is zero
        4: begin odds = 16'd256; limit = 31'($urandom_range(1 << 20)); end
        5: begin odds = 16'($urandom()); limit = 31'($urandom_range(1 << 22)); end
        6: begin odds = 16'($urandom()); limit = 31'd0; end
        default: begin
          odds  = 16'($urandom_range(1024, 1));
          limit = 31'($urandom());
        end
      endcase
      set_register(REG_ODDS_RATIO, {16'd0, odds});
      set_register(REG_ALARM_THRESHOLD, {1'b0, limit});
      set_idling(p % 4);
      adverse_pct = $urandom_range(85, 15);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        case ($urandom_range(9))
          0:       r = 17'd0;
          1:       r = RISK_ONE;
          2:       r = 17'($urandom_range(131071, 65537));
          3, 4:    r = 17'($urandom_range(131071));
          default: r = 17'($urandom_range(65536));
        endcase
        send_request(r, $urandom_range(99) < adverse_pct);
      end
      drain_results();
    end

    // climbs at the widest limit: upper then lower sum move far from zero
    set_idling(IDLE_NONE);
    set_register(REG_ALARM_THRESHOLD, {1'b0, UPPER_MAX});
    set_register(REG_ODDS_RATIO, 32'd1);
    for (int n = 0; n < CLIMB_ITEMS; n++)
      send_request(17'($urandom_range(131071, 65536)), 1'b0);
    drain_results();
    set_register(REG_ODDS_RATIO, 32'hffff);
    for (int n = 0; n < CLIMB_ITEMS; n++)
      send_request(17'($urandom_range(131071, 65536)), 1'b0);
    drain_results();

    // quiet tail: nothing more may come out
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("%0d requests over %0d phases, %0d results checked", requests_taken,
             PHASES + 3, results_checked);
    $display("restarts upper %0d lower %0d, saturations upper %0d lower %0d",
             upper_restarts, lower_restarts, upper_clips, lower_clips);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS risk_adjusted_cusum");
    end else begin
      $display("%0d mismatches, %0d results still owed", mismatches,
               pending_results.size());
      $display("FAIL risk_adjusted_cusum");
    end
    $finish;
  end

  // watchdog: several times the slowest legal run
  initial begin
    #(64'd50_000_000);
    $display("timeout with %0d results still owed", pending_results.size());
    $display("FAIL risk_adjusted_cusum");
    $finish;
  end

endmodule
